@@ rtl/cfra_pkg.sv @@
`timescale 1ns / 1ps

package cfra_pkg;

  localparam int FRAC_BITS   = 32;
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_TERMS   = 128;
  localparam int WORD_W      = 64;
  localparam int CNT_W       = 6;
  localparam int TERM_W      = 8;
  localparam int DENOM_W     = 33;
  localparam int TOL_W       = 6;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_DATA_W  = 112;

  localparam logic CFG_TOL_SHIFT  = 1'b0;
  localparam logic CFG_TERM_LIMIT = 1'b1;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } cfra_op_t;

  typedef struct packed {
    logic     start;
    cfra_op_t op;
  } cfra_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MULH,
    S_MULK,
    S_MULE,
    S_OUT
  } cfra_state_t;

endpackage

@@ rtl/cfra_unit.sv @@
`timescale 1ns / 1ps

// Shared bit-serial arithmetic unit: restoring divide or shift-add multiply,
// one bit per cycle over a 64-bit operand. For a divide, res_lo is the
// quotient and res_hi the remainder; for a multiply, {res_hi, res_lo} is the
// full product.
module cfra_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cfra_pkg::cfra_cmd_t                   cmd,
  input  logic [cfra_pkg::WORD_W-1:0]           a,
  input  logic [cfra_pkg::WORD_W-1:0]           b,
  output logic                                  done,
  output logic [cfra_pkg::WORD_W-1:0]           res_lo,
  output logic [cfra_pkg::WORD_W-1:0]           res_hi
);

  localparam int W = cfra_pkg::WORD_W;

  cfra_pkg::cfra_op_t      op_r;
  logic                    busy_r;
  logic                    done_r;
  logic [cfra_pkg::CNT_W-1:0] cnt_r;
  logic [W-1:0]            x_r;
  logic [W-1:0]            b_r;
  logic [2*W-1:0]          acc_r;

  logic [W:0]              div_t;
  logic [W:0]              div_diff;
  logic                    div_ge;
  logic [2*W-1:0]          mul_sum;

  always_comb begin
    div_t    = {acc_r[W-1:0], x_r[W-1]};
    div_ge   = div_t >= {1'b0, b_r};
    div_diff = div_t - {1'b0, b_r};
    mul_sum  = {acc_r[2*W-2:0], 1'b0} + (x_r[W-1] ? {{W{1'b0}}, b_r} : {(2*W){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {cfra_pkg::CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      x_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      case (op_r)
        cfra_pkg::OP_DIV: begin
          x_r   <= {x_r[W-2:0], div_ge};
          acc_r <= {{W{1'b0}}, (div_ge ? div_diff[W-1:0] : div_t[W-1:0])};
        end
        cfra_pkg::OP_MUL: begin
          x_r   <= {x_r[W-2:0], 1'b0};
          acc_r <= mul_sum;
        end
        default: begin
          x_r <= x_r;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign res_lo = (op_r == cfra_pkg::OP_DIV) ? x_r : acc_r[W-1:0];
  assign res_hi = (op_r == cfra_pkg::OP_DIV) ? acc_r[W-1:0] : acc_r[2*W-1:W];

endmodule

@@ rtl/continued_fraction_rational_approx.sv @@
`timescale 1ns / 1ps

// Channel | Ports                         | Contents
// in      | in_tvalid/in_tready/in_tdata   | value
// out     | out_tvalid/out_tready/out_tdata| numer, denom, term_count, found
// cfg     | cfg_we/cfg_index/cfg_wdata     | tol_shift, term_limit
//
// Each term takes one check state plus one divide and three multiplies, each over the
// full 64-bit operand on the shared bit-serial unit. An item ended by the term limit
// passes through the check state once more before its output.
// Reset sets tol_shift to 43 and term_limit to 128 and empties the output.
// One item is worked at a time; a finished result waits in the output register
// and a new item is taken while it waits. Output stalls hold the sequencer only.
module continued_fraction_rational_approx (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [63:0] numer, [96:64] denom, [104:97] term_count,
                                   // [105] found, [111:106] zero
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_wdata
);

  localparam int W = cfra_pkg::WORD_W;

  cfra_pkg::cfra_state_t state_r, state_nxt;
  cfra_pkg::cfra_cmd_t   cmd;

  logic [cfra_pkg::TOL_W-1:0]  tol_shift_r;
  logic [cfra_pkg::TERM_W-1:0] term_limit_r;
  logic [cfra_pkg::TERM_W-1:0] limit_r;
  logic [cfra_pkg::TERM_W-1:0] count_r;
  logic        neg_r;
  logic        ok_r;
  logic [W-1:0] m_r, p_r, q_r, s_r, r_r;
  logic [W-1:0] h_r, h1_r, h2_r, k_r, k1_r, k2_r;

  logic [W-1:0] op_a, op_b;
  logic         u_done;
  logic [W-1:0] u_lo, u_hi;
  logic [W-1:0] k_new;
  logic [2*W-1:0] err_sh;
  logic         tol_met;

  logic                         out_valid_r;
  logic [W-1:0]                 out_numer_r;
  logic [cfra_pkg::DENOM_W-1:0] out_denom_r;
  logic [cfra_pkg::TERM_W-1:0]  out_count_r;
  logic                         out_found_r;

  logic in_fire, out_free;

  assign in_tready = (state_r == cfra_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign k_new   = u_lo + k2_r;
  assign err_sh  = {{W{1'b0}}, r_r} << tol_shift_r;
  assign tol_met = err_sh <= {u_hi, u_lo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_shift_r  <= cfra_pkg::TOL_W'(43);
      term_limit_r <= cfra_pkg::TERM_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        cfra_pkg::CFG_TOL_SHIFT:  tol_shift_r  <= cfg_wdata[cfra_pkg::TOL_W-1:0];
        cfra_pkg::CFG_TERM_LIMIT: term_limit_r <= cfg_wdata;
        default: tol_shift_r <= tol_shift_r;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfra_pkg::S_IDLE:  if (in_fire) state_nxt = cfra_pkg::S_CHECK;
      cfra_pkg::S_CHECK: begin
        if (count_r < limit_r && q_r != '0) state_nxt = cfra_pkg::S_DIV;
        else state_nxt = cfra_pkg::S_OUT;
      end
      cfra_pkg::S_DIV:   if (u_done) state_nxt = cfra_pkg::S_MULH;
      cfra_pkg::S_MULH:  if (u_done) state_nxt = cfra_pkg::S_MULK;
      cfra_pkg::S_MULK:  if (u_done) state_nxt = cfra_pkg::S_MULE;
      cfra_pkg::S_MULE: begin
        if (u_done) state_nxt = tol_met ? cfra_pkg::S_OUT : cfra_pkg::S_CHECK;
      end
      cfra_pkg::S_OUT:   if (out_free) state_nxt = cfra_pkg::S_IDLE;
      default: state_nxt = cfra_pkg::S_IDLE;
    endcase
  end

  // Unit commands.
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = cfra_pkg::OP_MUL;
    op_a      = s_r;
    op_b      = h1_r;
    case (state_r)
      cfra_pkg::S_CHECK: begin
        cmd.start = count_r < limit_r && q_r != '0;
        cmd.op    = cfra_pkg::OP_DIV;
        op_a      = p_r;
        op_b      = q_r;
      end
      cfra_pkg::S_DIV: begin
        cmd.start = u_done;
        op_a      = u_lo;
        op_b      = h1_r;
      end
      cfra_pkg::S_MULH: begin
        cmd.start = u_done;
        op_a      = s_r;
        op_b      = k1_r;
      end
      cfra_pkg::S_MULK: begin
        cmd.start = u_done;
        op_a      = k_new;
        op_b      = m_r;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  cfra_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .a      (op_a),
    .b      (op_b),
    .done   (u_done),
    .res_lo (u_lo),
    .res_hi (u_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cfra_pkg::S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cfra_pkg::S_IDLE: begin
        if (in_fire) begin
          neg_r   <= in_tdata[cfra_pkg::VALUE_WIDTH-1];
          m_r     <= in_tdata[cfra_pkg::VALUE_WIDTH-1] ? (~in_tdata + 1'b1) : in_tdata;
          p_r     <= in_tdata[cfra_pkg::VALUE_WIDTH-1] ? (~in_tdata + 1'b1) : in_tdata;
          q_r     <= W'(1) << cfra_pkg::FRAC_BITS;
          h1_r    <= W'(1);
          h2_r    <= '0;
          k1_r    <= '0;
          k2_r    <= W'(1);
          h_r     <= '0;
          k_r     <= W'(1);
          count_r <= '0;
          ok_r    <= 1'b0;
          limit_r <= (term_limit_r > cfra_pkg::TERM_W'(cfra_pkg::MAX_TERMS)) ?
                     cfra_pkg::TERM_W'(cfra_pkg::MAX_TERMS) : term_limit_r;
        end
      end
      cfra_pkg::S_DIV: begin
        if (u_done) begin
          s_r <= u_lo;
          r_r <= u_hi;
        end
      end
      cfra_pkg::S_MULH: begin
        if (u_done) h_r <= u_lo + h2_r;
      end
      cfra_pkg::S_MULK: begin
        if (u_done) begin
          k_r     <= k_new;
          h2_r    <= h1_r;
          h1_r    <= h_r;
          k2_r    <= k1_r;
          k1_r    <= k_new;
          count_r <= count_r + 1'b1;
        end
      end
      cfra_pkg::S_MULE: begin
        if (u_done) begin
          if (tol_met) begin
            ok_r <= 1'b1;
          end else begin
            p_r <= q_r;
            q_r <= r_r;
          end
        end
      end
      cfra_pkg::S_OUT: begin
        if (out_free) begin
          out_numer_r <= neg_r ? (W'(0) - h_r) : h_r;
          out_denom_r <= k_r[cfra_pkg::DENOM_W-1:0];
          out_count_r <= count_r;
          out_found_r <= ok_r;
        end
      end
      default: ok_r <= ok_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_found_r, out_count_r, out_denom_r, out_numer_r};

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == cfra_pkg::S_DIV || state_r == cfra_pkg::S_MULH ||
                state_r == cfra_pkg::S_MULK || state_r == cfra_pkg::S_MULE))
    else $error("unit finished outside a wait state");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while one is being worked");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_count_r <= cfra_pkg::TERM_W'(cfra_pkg::MAX_TERMS))
    else $error("term count above the limit");

  a_found_terms: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_found_r |-> out_count_r != '0)
    else $error("found set with no term taken");
`endif

endmodule
